>>> rtl/core/plc_pkg.sv
// Shared types and constants of the per-address connection limiter.
// Depends on nothing; every other file refers to it by scoped names.
package plc_pkg;

  localparam int unsigned DefEntries = 256;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned CountW     = 16;
  localparam int unsigned RspDepth   = 2;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;
  localparam logic [CountW-1:0] MaxReset = CountW'(16);

  // register index, taken from paddr[2]
  localparam logic RegMaxPerAddr = 1'b0;

  typedef enum logic {
    KindAdd    = 1'b0,
    KindRemove = 1'b1
  } plc_kind_e;

  typedef enum logic [1:0] {
    StDone    = 2'd0,
    StRefused = 2'd1,
    StFull    = 2'd2,
    StAbsent  = 2'd3
  } plc_status_e;

  // one table entry held by a cell
  typedef struct packed {
    logic              valid;
    logic [KeyW-1:0]   key;
    logic [CountW-1:0] count;
  } plc_ent_t;

  // operation word travelling down the cell chain
  typedef struct packed {
    logic              active;
    plc_kind_e         kind;
    logic [KeyW-1:0]   key;
    logic              done;
    logic              shift;
    plc_status_e       status;
    logic [CountW-1:0] count;
  } plc_word_t;

  typedef struct packed {
    plc_status_e       status;
    logic [CountW-1:0] count;
  } plc_rsp_t;

endpackage

>>> rtl/core/plc_if.sv
// Request and response channel interfaces of the connection limiter.
// Depends on plc_pkg for field widths.
interface plc_req_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [plc_pkg::KeyW-1:0]    ip_addr;

  modport source (output valid, output kind, output ip_addr, input ready);
  modport sink (input valid, input kind, input ip_addr, output ready);
endinterface

interface plc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [plc_pkg::CountW-1:0]  count_after;

  modport source (output valid, output status, output count_after, input ready);
  modport sink (input valid, input status, input count_after, output ready);
endinterface

>>> rtl/core/plc_cell.sv
// One cell of the limiter table: holds one entry and one stage of the word chain.
// Depends on plc_pkg.
module plc_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [plc_pkg::CountW-1:0] max_i,
  input  plc_pkg::plc_word_t         word_i,
  output plc_pkg::plc_word_t         word_o,
  input  plc_pkg::plc_ent_t          nbr_i,
  output plc_pkg::plc_ent_t          ent_o
);

  logic                       valid_q, valid_d;
  logic [plc_pkg::KeyW-1:0]   key_q, key_d;
  logic [plc_pkg::CountW-1:0] cnt_q, cnt_d;
  logic                       act_q;
  plc_pkg::plc_word_t         word_q, word_d;
  logic                       hit;
  logic [plc_pkg::CountW-1:0] dec;

  assign hit = valid_q && (key_q == word_i.key);
  assign dec = cnt_q - plc_pkg::CountW'(1);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    cnt_d   = cnt_q;
    word_d  = word_i;
    if (word_i.active) begin
      if (word_i.shift) begin
        // close the gap left upstream: take the neighbor's entry
        valid_d = nbr_i.valid;
        key_d   = nbr_i.key;
        cnt_d   = nbr_i.count;
      end else if (!word_i.done) begin
        if (hit) begin
          word_d.done   = 1'b1;
          word_d.status = plc_pkg::StDone;
          if (word_i.kind == plc_pkg::KindAdd) begin
            if (cnt_q >= max_i) begin
              word_d.status = plc_pkg::StRefused;
              word_d.count  = cnt_q;
            end else begin
              cnt_d        = cnt_q + plc_pkg::CountW'(1);
              word_d.count = cnt_q + plc_pkg::CountW'(1);
            end
          end else begin
            word_d.count = dec;
            if (dec == '0) begin
              valid_d      = nbr_i.valid;
              key_d        = nbr_i.key;
              cnt_d        = nbr_i.count;
              word_d.shift = 1'b1;
            end else begin
              cnt_d = dec;
            end
          end
        end else if (!valid_q) begin
          // first free cell ends the valid prefix: key is absent
          word_d.done = 1'b1;
          if (word_i.kind == plc_pkg::KindAdd) begin
            valid_d       = 1'b1;
            key_d         = word_i.key;
            cnt_d         = plc_pkg::CountW'(1);
            word_d.status = plc_pkg::StDone;
            word_d.count  = plc_pkg::CountW'(1);
          end else begin
            word_d.status = plc_pkg::StAbsent;
            word_d.count  = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      act_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      act_q   <= word_i.active;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    cnt_q  <= cnt_d;
    word_q <= word_d;
  end

  always_comb begin
    word_o        = word_q;
    word_o.active = act_q;
  end

  assign ent_o = '{valid: valid_q, key: key_q, count: cnt_q};

endmodule

>>> rtl/core/plc_rsp_buf.sv
// Small result queue between the cell chain and the response channel.
// Depends on plc_pkg.
module plc_rsp_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  plc_pkg::plc_rsp_t data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic              room_o,
  output plc_pkg::plc_rsp_t data_o
);

  localparam int unsigned PtrW = (plc_pkg::RspDepth > 1) ? $clog2(plc_pkg::RspDepth) : 1;
  localparam int unsigned CntW = $clog2(plc_pkg::RspDepth + 1);

  plc_pkg::plc_rsp_t mem_q [plc_pkg::RspDepth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_pop;

  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];
  // room for one more word once any word leaves this cycle
  assign room_o  = (cnt_q < CntW'(plc_pkg::RspDepth)) || do_pop;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(plc_pkg::RspDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(plc_pkg::RspDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/plc_cfg_regs.sv
// APB-style configuration register of the connection limiter.
// Depends on plc_pkg.
module plc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [plc_pkg::ApbAddrW-1:0] paddr,
  input  logic [plc_pkg::ApbDataW-1:0] pwdata,
  output logic [plc_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  output logic [plc_pkg::CountW-1:0]   max_o
);

  logic [plc_pkg::CountW-1:0] max_q, max_d;
  logic                       sel_max;

  assign pready  = 1'b1;
  assign sel_max = (paddr[2] == plc_pkg::RegMaxPerAddr);

  always_comb begin
    max_d = max_q;
    if (psel && penable && pwrite && sel_max) begin
      max_d = pwdata[plc_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= plc_pkg::MaxReset;
    end else begin
      max_q <= max_d;
    end
  end

  assign prdata = sel_max ? plc_pkg::ApbDataW'(max_q) : '0;
  assign max_o  = max_q;

endmodule

>>> rtl/core/per_address_connection_limiter_unit.sv
// Per-address connection limiter: a table of IPv4 addresses with open-use counts.
// Depends on plc_pkg, plc_if, plc_cell, plc_rsp_buf and plc_cfg_regs.
//
// Each request word (add or remove one use of an address) walks down a chain of
// Entries cells, one cell per cycle; every cell holds one table entry. Valid
// entries always sit at the front of the chain, so the first empty cell marks
// the end of the table: an add that reaches it inserts the address with count
// one, a remove that reaches it reports the address absent. A remove that
// brings a count to zero slides every later entry up by one cell as the word
// moves on. One word is in the chain at a time; its result is written into a
// two-deep response queue when the word leaves the last cell and is offered on
// the response channel from the next cycle on. No new request is taken until
// the word has left the chain, nor while the queue has no room. The next
// request is accepted while earlier results still wait in the queue.
// Reset clears every entry at once; no clearing pass.
// Status codes: done, refused at limit, table full, address absent.
module per_address_connection_limiter_unit #(
  parameter int unsigned Entries = plc_pkg::DefEntries
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  plc_req_if.sink                      req_i,
  plc_rsp_if.source                    rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [plc_pkg::ApbAddrW-1:0] paddr,
  input  logic [plc_pkg::ApbDataW-1:0] pwdata,
  output logic [plc_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);

  logic [plc_pkg::CountW-1:0] max_s;
  plc_pkg::plc_word_t         word_s [Entries+1];
  plc_pkg::plc_ent_t          ent_s  [Entries];
  plc_pkg::plc_word_t         exit_w;
  plc_pkg::plc_rsp_t          rsp_d, rsp_s;
  logic                       busy_q, busy_d;
  logic                       accept, buf_room, buf_valid;

  plc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_o   (max_s)
  );

  // Admit one word at a time, and only with queue room for its result.
  assign req_i.ready = !busy_q && buf_room;
  assign accept      = req_i.valid && req_i.ready;

  assign word_s[0] = '{active: accept,
                       kind:   plc_pkg::plc_kind_e'(req_i.kind),
                       key:    req_i.ip_addr,
                       done:   1'b0,
                       shift:  1'b0,
                       status: plc_pkg::StDone,
                       count:  '0};

  for (genvar i = 0; i < Entries; i++) begin : g_cell
    plc_pkg::plc_ent_t nbr;
    if (i == Entries - 1) begin : g_last
      // past the last cell the chain reads as empty
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = ent_s[i+1];
    end
    plc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .max_i  (max_s),
      .word_i (word_s[i]),
      .word_o (word_s[i+1]),
      .nbr_i  (nbr),
      .ent_o  (ent_s[i])
    );
  end

  assign exit_w = word_s[Entries];

  // A word that left the chain unresolved met a full table with no match.
  always_comb begin
    rsp_d.status = exit_w.status;
    rsp_d.count  = exit_w.count;
    if (!exit_w.done) begin
      rsp_d.status = (exit_w.kind == plc_pkg::KindAdd) ? plc_pkg::StFull
                                                       : plc_pkg::StAbsent;
      rsp_d.count  = '0;
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (exit_w.active) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  plc_rsp_buf u_rsp_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (exit_w.active),
    .data_i  (rsp_d),
    .pop_i   (rsp_o.ready),
    .valid_o (buf_valid),
    .room_o  (buf_room),
    .data_o  (rsp_s)
  );

  assign rsp_o.valid       = buf_valid;
  assign rsp_o.status      = rsp_s.status;
  assign rsp_o.count_after = rsp_s.count;

endmodule
